/* src/s256h_pkg.sv */
// ----------------------------------------------------------------------------
// s256h_pkg
// types, constants and the rotate function shared by the sha-256 stream hasher
// ----------------------------------------------------------------------------
package s256h_pkg;

  localparam logic [31:0] IV [8] = '{
    32'h6A09E667, 32'hBB67AE85, 32'h3C6EF372, 32'hA54FF53A,
    32'h510E527F, 32'h9B05688C, 32'h1F83D9AB, 32'h5BE0CD19
  };

  localparam logic [31:0] RK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUNDS,
    ST_PAD1,
    ST_PAD2,
    ST_OUT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic take_byte;   // store byte and count it
    logic load_pad1;   // write 0x80, zero fill and, when it fits, the length
    logic load_pad2;   // write zero fill and length block
    logic start;       // copy chain hash into working regs
    logic round;       // one compression round
    logic fold;        // add working regs into chain hash
    logic restart;     // restore iv and clear the count
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic block_full;  // byte position is 63
    logic two_blocks;  // padding needs a second block
    logic last_round;  // round counter at 63
  } stat_t;

  function automatic logic [31:0] rotr(input logic [31:0] x, input logic [4:0] n);
    rotr = (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

endpackage

/* src/s256h_if.sv */
// ----------------------------------------------------------------------------
// s256h_in_if / s256h_out_if
// valid/ready channels for message bytes and digest words
// ----------------------------------------------------------------------------
interface s256h_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;
  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface s256h_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* src/s256h_ctrl.sv */
// ----------------------------------------------------------------------------
// s256h_ctrl
// sequencer for byte intake, compression, padding and digest output
// ----------------------------------------------------------------------------
module s256h_ctrl
  import s256h_pkg::*;
(
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  input  logic   in_present,
  input  logic   in_end,
  output logic   in_ready,
  input  logic   out_done,
  input  stat_t  stat,
  output cmd_t   cmd,
  output state_t state_out
);

  state_t state, state_next;
  logic   fin, fin_next;   // a padding pass follows the current compression
  logic   pad2, pad2_next; // the pending compression is the first of two pad blocks
  logic   acc;
  // set once padding has been loaded for the final block
  logic   done_pad, done_pad_next;

  assign acc       = in_valid && in_ready;
  assign in_ready  = (state == ST_IDLE);
  assign state_out = state;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fin   <= 1'b0;
      pad2  <= 1'b0;
    end else begin
      state <= state_next;
      fin   <= fin_next;
      pad2  <= pad2_next;
    end
  end

  always_comb begin
    state_next = state;
    fin_next   = fin;
    pad2_next  = pad2;
    unique case (state)
      ST_IDLE: begin
        if (acc) begin
          fin_next = in_end;
          if (in_present && stat.block_full) begin
            state_next = ST_ROUNDS;
          end else if (in_end) begin
            state_next = ST_PAD1;
          end
        end
      end
      ST_ROUNDS: begin
        if (stat.last_round) begin
          if (pad2) begin
            pad2_next  = 1'b0;
            state_next = ST_PAD2;
          end else if (fin) begin
            fin_next   = 1'b0;
            state_next = ST_PAD1;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_PAD1: begin
        pad2_next  = stat.two_blocks;
        state_next = ST_ROUNDS;
        fin_next   = 1'b0;
        if (!stat.two_blocks) begin
          pad2_next = 1'b0;
        end
      end
      ST_PAD2: state_next = ST_ROUNDS;
      ST_OUT: begin
        if (out_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
    // last padding compression leads to output
    if (state == ST_ROUNDS && stat.last_round && !pad2 && !fin && done_pad) begin
      state_next = ST_OUT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done_pad <= 1'b0;
    end else begin
      done_pad <= done_pad_next;
    end
  end

  always_comb begin
    done_pad_next = done_pad;
    if (state == ST_PAD1 && !stat.two_blocks) begin
      done_pad_next = 1'b1;
    end
    if (state == ST_PAD2) begin
      done_pad_next = 1'b1;
    end
    if (state == ST_OUT) begin
      done_pad_next = 1'b0;
    end
  end

  always_comb begin
    cmd           = '0;
    cmd.take_byte = acc && in_present;
    cmd.load_pad1 = (state == ST_PAD1);
    cmd.load_pad2 = (state == ST_PAD2);
    cmd.start     = (state == ST_PAD1) || (state == ST_PAD2) ||
                    (acc && in_present && stat.block_full);
    cmd.round     = (state == ST_ROUNDS);
    cmd.fold      = (state == ST_ROUNDS) && stat.last_round;
    cmd.restart   = (state == ST_OUT) && out_done;
  end

endmodule

/* src/s256h_dp.sv */
// ----------------------------------------------------------------------------
// s256h_dp
// block buffer, byte count, message schedule and one-round compression unit
// ----------------------------------------------------------------------------
module s256h_dp
  import s256h_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic [7:0]  data_byte,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  out_sel,
  output logic [31:0] out_word
);

  logic [31:0] chain [8];
  logic [31:0] wk [8];
  logic [31:0] blk [16];
  logic [63:0] count;
  logic [5:0]  rnd;

  logic [5:0]  pos;
  logic [3:0]  wi;
  logic [4:0]  sh;
  logic [31:0] keep, padw;
  logic [63:0] bits;
  logic [31:0] w_new, wr, s0, s1, t1, t2, x15, x2;

  assign pos  = count[5:0];
  assign wi   = pos[5:2];
  assign sh   = {~pos[1:0], 3'b000};
  assign keep = (pos[1:0] != 2'd0) ? (blk[wi] & (32'hFFFFFFFF << ({1'b0, sh} + 6'd8))) : '0;
  assign padw = keep | (32'h00000080 << sh);
  assign bits = {count[60:0], 3'b000};

  assign stat.block_full = (pos == 6'd63);
  assign stat.two_blocks = (pos > 6'd55);
  assign stat.last_round = (rnd == 6'd63);

  // schedule: blk acts as a 16-word shift window during rounds
  assign x15   = blk[1];
  assign x2    = blk[14];
  assign s0    = rotr(x15, 5'd7) ^ rotr(x15, 5'd18) ^ (x15 >> 3);
  assign s1    = rotr(x2, 5'd17) ^ rotr(x2, 5'd19) ^ (x2 >> 10);
  assign w_new = blk[0] + s0 + blk[9] + s1;
  assign wr    = blk[0];

  assign t1 = wk[7] + (rotr(wk[4], 5'd6) ^ rotr(wk[4], 5'd11) ^ rotr(wk[4], 5'd25))
            + (wk[6] ^ (wk[4] & (wk[5] ^ wk[6]))) + RK[rnd] + wr;
  assign t2 = (rotr(wk[0], 5'd2) ^ rotr(wk[0], 5'd13) ^ rotr(wk[0], 5'd22))
            + ((wk[0] & wk[1]) | (wk[2] & (wk[0] ^ wk[1])));

  assign out_word = chain[out_sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      rnd   <= '0;
      for (int i = 0; i < 8; i++) chain[i] <= IV[i];
    end else begin
      if (cmd.take_byte) begin
        count <= count + 64'd1;
      end
      if (cmd.start) begin
        rnd <= '0;
        for (int i = 0; i < 8; i++) wk[i] <= chain[i];
      end
      if (cmd.round) begin
        rnd   <= rnd + 6'd1;
        wk[7] <= wk[6];
        wk[6] <= wk[5];
        wk[5] <= wk[4];
        wk[4] <= wk[3] + t1;
        wk[3] <= wk[2];
        wk[2] <= wk[1];
        wk[1] <= wk[0];
        wk[0] <= t1 + t2;
        for (int i = 0; i < 15; i++) blk[i] <= blk[i+1];
        blk[15] <= w_new;
      end
      if (cmd.fold) begin
        chain[0] <= chain[0] + t1 + t2;
        chain[1] <= chain[1] + wk[0];
        chain[2] <= chain[2] + wk[1];
        chain[3] <= chain[3] + wk[2];
        chain[4] <= chain[4] + wk[3] + t1;
        chain[5] <= chain[5] + wk[4];
        chain[6] <= chain[6] + wk[5];
        chain[7] <= chain[7] + wk[6];
      end
      if (cmd.restart) begin
        count <= '0;
        for (int i = 0; i < 8; i++) chain[i] <= IV[i];
      end
    end
    if (cmd.take_byte) begin
      if (pos[1:0] == 2'd0) begin
        blk[wi] <= {data_byte, 24'd0};
      end else begin
        blk[wi] <= blk[wi] | ({24'd0, data_byte} << sh);
      end
    end
    if (cmd.load_pad1) begin
      for (int i = 0; i < 16; i++) begin
        if (i[3:0] > wi) begin
          if (!stat.two_blocks && i == 14) begin
            blk[i] <= bits[63:32];
          end else if (!stat.two_blocks && i == 15) begin
            blk[i] <= bits[31:0];
          end else begin
            blk[i] <= '0;
          end
        end
      end
      blk[wi] <= padw;
    end
    if (cmd.load_pad2) begin
      for (int i = 0; i < 14; i++) blk[i] <= '0;
      blk[14] <= bits[63:32];
      blk[15] <= bits[31:0];
    end
  end

endmodule

/* src/sha256_byte_stream_hasher.sv */
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// sha-256 over a byte stream, eight digest words per message
// ----------------------------------------------------------------------------
// a byte is taken while the hasher is idle; the 64th byte of a block starts
// the compression rounds on the single round unit
// an end item adds one or two padding passes, then 8 output items
// no item is accepted during rounds, padding loads or digest output
// synchronous reset loads the initial hash and clears the byte count
module sha256_byte_stream_hasher
  import s256h_pkg::*;
(
  input logic         clk,
  input logic         rst,
  s256h_in_if.sink    in_ch,
  s256h_out_if.source out_ch
);

  cmd_t        cmd;
  stat_t       stat;
  state_t      state;
  logic [2:0]  idx;
  logic [31:0] word;
  logic        out_done;

  assign out_done = out_ch.valid && out_ch.ready && (idx == 3'd7);

  s256h_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_ch.valid),
    .in_present (in_ch.byte_present),
    .in_end     (in_ch.end_of_message),
    .in_ready   (in_ch.ready),
    .out_done   (out_done),
    .stat       (stat),
    .cmd        (cmd),
    .state_out  (state)
  );

  s256h_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .data_byte (in_ch.data_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_sel   (idx),
    .out_word  (word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (out_ch.valid && out_ch.ready) begin
      idx <= idx + 3'd1;
    end
  end

  assign out_ch.valid       = (state == ST_OUT);
  assign out_ch.digest_word = word;
  assign out_ch.word_index  = idx;
  assign out_ch.last_word   = (idx == 3'd7);

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ch.ready && out_ch.valid)) else $error("input open during output");
  a_idx_wrap: assert property (@(posedge clk) disable iff (rst)
    out_done |=> (idx == 3'd0) && !out_ch.valid) else $error("output did not close");
  a_idle_idx: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> idx == 3'd0) else $error("word index not cleared");

endmodule
